FILE: design/vec3_pkg.sv
`default_nettype none
package vec3_pkg;

  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_SCALE  = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_DOT    = 4'd4;
  localparam logic [3:0] OP_CROSS  = 4'd5;
  localparam logic [3:0] OP_LENGTH = 4'd6;
  localparam logic [3:0] OP_NORM   = 4'd7;
  localparam logic [3:0] OP_EQUAL  = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 32;
  localparam int SQ_STAGES     = 16;
  localparam int DV_STAGES     = 9;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    logic [3:0] op;
    q16_t       ax;
    q16_t       ay;
    q16_t       az;
    q16_t       bx;
    q16_t       by;
    q16_t       bz;
    q16_t       s;
    logic       eq;
  } item_t;

  typedef struct packed {
    q16_t       rx;
    q16_t       ry;
    q16_t       rz;
    q16_t       sc;
    logic       eq;
    logic [1:0] st;
  } res_t;

  typedef struct packed {
    logic [3:0]       op;
    res_t             res;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } ctl_t;

  typedef struct packed {
    logic [63:0] n;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [17:0] num;
    logic [32:0] rem;
    logic [17:0] q;
  } dv_t;

  typedef struct packed {
    q16_t val;
    logic ovf;
  } sat_t;

  function automatic sat_t sat32(logic signed [49:0] v);
    sat_t r;
    if (v > 50'sd2147483647) begin
      r.val = Q_MAX;
      r.ovf = 1'b1;
    end else if (v < -50'sd2147483648) begin
      r.val = Q_MIN;
      r.ovf = 1'b1;
    end else begin
      r.val = v[31:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // product shifted by 16, rounded toward zero
  function automatic logic signed [47:0] trunc16(logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? 64'sd65535 : 64'sd0);
    return t[63:16];
  endfunction

  function automatic sq_t sqrt_step(sq_t c);
    sq_t r;
    logic [35:0] trial;
    logic [35:0] d;
    trial = {c.rem, c.n[63:62]};
    d = {2'b00, c.root, 2'b01};
    r.n = {c.n[61:0], 2'b00};
    if (trial >= d) begin
      r.rem = 34'(trial - d);
      r.root = {c.root[30:0], 1'b1};
    end else begin
      r.rem = trial[33:0];
      r.root = {c.root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic sq_t sqrt_step2(sq_t c);
    return sqrt_step(sqrt_step(c));
  endfunction

  function automatic dv_t div_step(dv_t c, logic [31:0] l);
    dv_t r;
    logic [32:0] t;
    t = {c.rem[31:0], c.num[17]};
    r.num = {c.num[16:0], 1'b0};
    if (t >= {1'b0, l}) begin
      r.rem = t - {1'b0, l};
      r.q = {c.q[16:0], 1'b1};
    end else begin
      r.rem = t;
      r.q = {c.q[16:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t div_step2(dv_t c, logic [31:0] l);
    return div_step(div_step(c, l), l);
  endfunction

endpackage
`default_nettype wire

FILE: design/vec3_fifo.sv
`default_nettype none
module vec3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0] wptr;
  logic [AW:0] rptr;
  logic do_push;
  logic do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign empty   = (wptr == rptr);
  assign full    = (wptr[AW-1:0] == rptr[AW-1:0]) && (wptr[AW] != rptr[AW]);
  assign rdata   = mem[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr[AW-1:0]] <= wdata;
  end

endmodule
`default_nettype wire

FILE: design/vec3_front.sv
`default_nettype none
module vec3_front
  import vec3_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [3:0] opcode,
  input  wire q16_t       ax,
  input  wire q16_t       ay,
  input  wire q16_t       az,
  input  wire q16_t       bx,
  input  wire q16_t       by,
  input  wire q16_t       bz,
  input  wire q16_t       scale_factor,
  input  wire logic       q_pop,
  output item_t           q_item,
  output logic            q_empty
);
  item_t item;

  always_comb begin
    item.op = opcode;
    item.ax = ax;
    item.ay = ay;
    item.az = az;
    item.bx = bx;
    item.by = by;
    item.bz = bz;
    item.s  = scale_factor;
    item.eq = (opcode == OP_EQUAL) && (ax == bx) && (ay == by) && (az == bz);
  end

  vec3_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(item),
    .full (full),
    .pop  (q_pop),
    .rdata(q_item),
    .empty(q_empty)
  );

endmodule
`default_nettype wire

FILE: design/vec3_back.sv
`default_nettype none
module vec3_back
  import vec3_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  wire item_t q_item,
  output logic       q_pop,
  input  wire logic  out_pop,
  output logic       out_push,
  output res_t       out_res
);
  localparam int CW = $clog2(OUT_DEPTH) + 1;

  logic [CW-1:0] used;
  logic issue;

  q16_t qa [3];
  q16_t qb [3];
  q16_t ma_sel [6];
  q16_t mb_sel [6];

  logic p1_vld, p2_vld, p3_vld;
  logic [3:0] p1_op, p2_op, p3_op;
  logic p1_eq, p2_eq, p3_eq;
  q16_t p1_a [3];
  q16_t p1_b [3];
  q16_t p1_ma [6];
  q16_t p1_mb [6];
  q16_t p2_a [3];
  q16_t p3_a [3];
  logic signed [32:0] p2_sum [3];
  logic signed [32:0] p3_sum [3];
  logic signed [63:0] p2_prod [6];
  logic signed [47:0] p3_tr [6];
  logic [63:0] p3_sq;

  ctl_t p4_ctl;
  sat_t s0, s1, s2, s3;

  logic [SQ_STAGES-1:0] sq_vld;
  ctl_t sq_ctl [SQ_STAGES];
  sq_t  sq_st [SQ_STAGES];
  sq_t  sq_init;

  logic [DV_STAGES-1:0] dv_vld;
  ctl_t dv_ctl [DV_STAGES];
  logic [31:0] dv_len [DV_STAGES];
  dv_t  dv_st [DV_STAGES][3];
  dv_t  dv_init [3];

  ctl_t fc;
  logic [31:0] flen;
  res_t f_res_next;
  res_t f_res;
  logic f_vld;

  assign issue = !q_empty && (used < CW'(OUT_DEPTH));
  assign q_pop = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + CW'(issue) - CW'(out_pop);
    end
  end

  // multiplier operand select
  always_comb begin
    qa[0] = q_item.ax;
    qa[1] = q_item.ay;
    qa[2] = q_item.az;
    qb[0] = q_item.bx;
    qb[1] = q_item.by;
    qb[2] = q_item.bz;
    for (int i = 0; i < 6; i++) begin
      ma_sel[i] = '0;
      mb_sel[i] = '0;
    end
    case (q_item.op)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma_sel[i] = qa[i];
          mb_sel[i] = q_item.s;
        end
      end
      OP_MUL, OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma_sel[i] = qa[i];
          mb_sel[i] = qb[i];
        end
      end
      OP_CROSS: begin
        ma_sel[0] = qa[1]; mb_sel[0] = qb[2];
        ma_sel[1] = qa[2]; mb_sel[1] = qb[1];
        ma_sel[2] = qa[2]; mb_sel[2] = qb[0];
        ma_sel[3] = qa[0]; mb_sel[3] = qb[2];
        ma_sel[4] = qa[0]; mb_sel[4] = qb[1];
        ma_sel[5] = qa[1]; mb_sel[5] = qb[0];
      end
      OP_LENGTH, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma_sel[i] = qa[i];
          mb_sel[i] = qa[i];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else begin
      p1_vld <= issue;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    p1_op <= q_item.op;
    p1_eq <= q_item.eq;
    for (int i = 0; i < 3; i++) begin
      p1_a[i] <= qa[i];
      p1_b[i] <= qb[i];
    end
    for (int i = 0; i < 6; i++) begin
      p1_ma[i] <= ma_sel[i];
      p1_mb[i] <= mb_sel[i];
    end

    p2_op <= p1_op;
    p2_eq <= p1_eq;
    for (int i = 0; i < 3; i++) begin
      p2_a[i] <= p1_a[i];
      if (p1_op == OP_SUB) begin
        p2_sum[i] <= {p1_a[i][31], p1_a[i]} - {p1_b[i][31], p1_b[i]};
      end else begin
        p2_sum[i] <= {p1_a[i][31], p1_a[i]} + {p1_b[i][31], p1_b[i]};
      end
    end
    for (int i = 0; i < 6; i++) begin
      p2_prod[i] <= p1_ma[i] * p1_mb[i];
    end

    p3_op <= p2_op;
    p3_eq <= p2_eq;
    for (int i = 0; i < 3; i++) begin
      p3_a[i] <= p2_a[i];
      p3_sum[i] <= p2_sum[i];
    end
    for (int i = 0; i < 6; i++) begin
      p3_tr[i] <= trunc16(p2_prod[i]);
    end
    p3_sq <= 64'(p2_prod[0]) + 64'(p2_prod[1]) + 64'(p2_prod[2]);
  end

  // result of every operation that needs no root
  always_comb begin
    s0 = '0;
    s1 = '0;
    s2 = '0;
    s3 = '0;
    case (p3_op)
      OP_ADD, OP_SUB: begin
        s0 = sat32(50'(p3_sum[0]));
        s1 = sat32(50'(p3_sum[1]));
        s2 = sat32(50'(p3_sum[2]));
      end
      OP_SCALE, OP_MUL: begin
        s0 = sat32(50'(p3_tr[0]));
        s1 = sat32(50'(p3_tr[1]));
        s2 = sat32(50'(p3_tr[2]));
      end
      OP_DOT: begin
        s3 = sat32(50'(p3_tr[0]) + 50'(p3_tr[1]) + 50'(p3_tr[2]));
      end
      OP_CROSS: begin
        s0 = sat32(50'(p3_tr[0]) - 50'(p3_tr[1]));
        s1 = sat32(50'(p3_tr[2]) - 50'(p3_tr[3]));
        s2 = sat32(50'(p3_tr[4]) - 50'(p3_tr[5]));
      end
      default: begin
      end
    endcase
    p4_ctl.op = p3_op;
    p4_ctl.res.rx = s0.val;
    p4_ctl.res.ry = s1.val;
    p4_ctl.res.rz = s2.val;
    p4_ctl.res.sc = s3.val;
    p4_ctl.res.eq = p3_eq;
    p4_ctl.res.st = (s0.ovf || s1.ovf || s2.ovf || s3.ovf) ? ST_SAT : ST_OK;
    for (int i = 0; i < 3; i++) begin
      p4_ctl.mag[i] = p3_a[i][31] ? 32'(-p3_a[i]) : 32'(p3_a[i]);
      p4_ctl.neg[i] = p3_a[i][31];
    end
    sq_init.n = p3_sq;
    sq_init.rem = '0;
    sq_init.root = '0;
  end

  // square root, two result bits per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= '0;
    end else begin
      sq_vld <= {sq_vld[SQ_STAGES-2:0], p3_vld};
    end
  end

  always_ff @(posedge clk) begin
    sq_ctl[0] <= p4_ctl;
    sq_st[0] <= sqrt_step2(sq_init);
    for (int i = 1; i < SQ_STAGES; i++) begin
      sq_ctl[i] <= sq_ctl[i-1];
      sq_st[i] <= sqrt_step2(sq_st[i-1]);
    end
  end

  // per component division by the length, two quotient bits per stage
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_init[k].rem = {3'b000, sq_ctl[SQ_STAGES-1].mag[k][31:2]};
      dv_init[k].num = {sq_ctl[SQ_STAGES-1].mag[k][1:0], 16'h0000};
      dv_init[k].q = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld <= '0;
    end else begin
      dv_vld <= {dv_vld[DV_STAGES-2:0], sq_vld[SQ_STAGES-1]};
    end
  end

  always_ff @(posedge clk) begin
    dv_ctl[0] <= sq_ctl[SQ_STAGES-1];
    dv_len[0] <= sq_st[SQ_STAGES-1].root;
    for (int k = 0; k < 3; k++) begin
      dv_st[0][k] <= div_step2(dv_init[k], sq_st[SQ_STAGES-1].root);
    end
    for (int i = 1; i < DV_STAGES; i++) begin
      dv_ctl[i] <= dv_ctl[i-1];
      dv_len[i] <= dv_len[i-1];
      for (int k = 0; k < 3; k++) begin
        dv_st[i][k] <= div_step2(dv_st[i-1][k], dv_len[i-1]);
      end
    end
  end

  // final select
  always_comb begin
    fc = dv_ctl[DV_STAGES-1];
    flen = dv_len[DV_STAGES-1];
    f_res_next = fc.res;
    case (fc.op)
      OP_LENGTH: begin
        if (flen[31]) begin
          f_res_next.sc = Q_MAX;
          f_res_next.st = ST_SAT;
        end else begin
          f_res_next.sc = flen;
          f_res_next.st = ST_OK;
        end
      end
      OP_NORM: begin
        if (flen == '0) begin
          f_res_next.st = ST_DIV0;
        end else begin
          f_res_next.rx = fc.neg[0] ? -32'(dv_st[DV_STAGES-1][0].q)
                                    : 32'(dv_st[DV_STAGES-1][0].q);
          f_res_next.ry = fc.neg[1] ? -32'(dv_st[DV_STAGES-1][1].q)
                                    : 32'(dv_st[DV_STAGES-1][1].q);
          f_res_next.rz = fc.neg[2] ? -32'(dv_st[DV_STAGES-1][2].q)
                                    : 32'(dv_st[DV_STAGES-1][2].q);
          f_res_next.st = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= dv_vld[DV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    f_res <= f_res_next;
  end

  assign out_push = f_vld;
  assign out_res  = f_res;

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(OUT_DEPTH))
    else $error("more requests in flight than output slots");

  a_pop_credited: assert property (@(posedge clk) disable iff (rst)
    out_pop |-> used != '0)
    else $error("result taken with no request in flight");

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    (f_vld && f_res.st == ST_DIV0) |-> (f_res.rx == '0 && f_res.ry == '0 && f_res.rz == '0))
    else $error("zero length normalize gave a nonzero vector");

  a_eq_ok: assert property (@(posedge clk) disable iff (rst)
    (f_vld && f_res.eq) |-> f_res.st == ST_OK)
    else $error("equal flag with nonzero status");

endmodule
`default_nettype wire

FILE: design/vector3_alu.sv
// vector3_alu: three-component signed Q16.16 vector unit
// input side is a queue: drive opcode, ax..bz and scale_factor with push;
// the request is taken on a clock edge with push high and full low
// output side is a queue: while empty is low the oldest result sits on
// rx, ry, rz, scalar_out, equal_flag and status; pop high takes it
// every request gives exactly one result, in request order
// throughput: one request per clock, sustained, for every opcode, while the
// receiver keeps popping; from push to empty going low the path runs through
// the multiplier stages, a 16-stage square root (two root bits per
// stage) and a 9-stage divider (two quotient bits per stage)
// results wait in a 32-entry output queue; in-flight requests are counted
// against its free space, so when the receiver stops popping the unit
// stops issuing and the input queue fills, then full rises
// rst (synchronous, active high) empties both queues and drops all
// requests in flight
`default_nettype none
module vector3_alu
  import vec3_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [3:0] opcode,
  input  wire q16_t       ax,
  input  wire q16_t       ay,
  input  wire q16_t       az,
  input  wire q16_t       bx,
  input  wire q16_t       by,
  input  wire q16_t       bz,
  input  wire q16_t       scale_factor,
  output logic            empty,
  input  wire logic       pop,
  output q16_t            rx,
  output q16_t            ry,
  output q16_t            rz,
  output q16_t            scalar_out,
  output logic            equal_flag,
  output logic [1:0]      status
);
  item_t q_item;
  logic  q_empty;
  logic  q_pop;
  logic  out_push;
  res_t  out_res;
  res_t  head;
  logic  out_full;
  logic  out_pop;

  assign out_pop = pop && !empty;

  vec3_front #(
    .MID_DEPTH(MID_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .ax          (ax),
    .ay          (ay),
    .az          (az),
    .bx          (bx),
    .by          (by),
    .bz          (bz),
    .scale_factor(scale_factor),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .q_empty     (q_empty)
  );

  vec3_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_pop (out_pop),
    .out_push(out_push),
    .out_res (out_res)
  );

  vec3_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .wdata(out_res),
    .full (out_full),
    .pop  (pop),
    .rdata(head),
    .empty(empty)
  );

  assign rx         = head.rx;
  assign ry         = head.ry;
  assign rz         = head.rz;
  assign scalar_out = head.sc;
  assign equal_flag = head.eq;
  assign status     = head.st;

  a_no_out_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result written into a full output queue");

endmodule
`default_nettype wire
